[rtl/core/stcr_pkg.sv]
// ----------------------------------------------------------------------------
// stcr_pkg
// Types, codes and helpers shared by the scaled text cell renderer.
// ----------------------------------------------------------------------------
package stcr_pkg;

    // Item function codes
    localparam logic [1:0] FUNC_PRINT   = 2'd0;
    localparam logic [1:0] FUNC_NEWLINE = 2'd1;
    localparam logic [1:0] FUNC_SETPOS  = 2'd2;

    // Register indexes (byte address is 4 * index)
    localparam logic [2:0] REG_COLUMN_OFFSET = 3'd0;
    localparam logic [2:0] REG_SCALE_CODE    = 3'd1;
    localparam logic [2:0] REG_CURSOR_ENABLE = 3'd2;
    localparam logic [2:0] REG_CURSOR_COL    = 3'd3;
    localparam logic [2:0] REG_CURSOR_ROW    = 3'd4;

    localparam logic [7:0] CURSOR_MARK = 8'h80;

    typedef struct packed {
        logic [1:0] func;
        logic [7:0] glyph_col_a;
        logic [7:0] glyph_col_b;
        logic [7:0] glyph_col_c;
        logic [7:0] glyph_col_d;
        logic [7:0] glyph_col_e;
        logic [7:0] new_col;
        logic [7:0] new_row;
    } stcr_cmd_t;

    typedef struct packed {
        logic [7:0] column_addr;
        logic [3:0] page_addr;
        logic [7:0] pixel_byte;
        logic [2:0] repeat_count;
        logic       last_of_cell;
    } stcr_res_t;

    typedef struct packed {
        logic [7:0] column_offset;
        logic [1:0] scale_code;
        logic       cursor_enable;
        logic [7:0] cursor_col;
        logic [7:0] cursor_row;
    } stcr_cfg_t;

    // One classified print, ready for rendering
    typedef struct packed {
        logic [4:0][7:0] glyph;
        logic            cursor;
        logic [7:0]      base_col;
        logic [3:0]      base_page;
        logic [1:0]      scale_code;
    } stcr_cell_t;

    typedef enum logic {
        BK_IDLE,
        BK_RUN
    } stcr_back_state_t;

    function automatic logic [2:0] scale_of(input logic [1:0] scode);
        logic [2:0] s;
        case (scode)
            2'd0:    s = 3'd1;
            2'd1:    s = 3'd2;
            default: s = 3'd4;
        endcase
        return s;
    endfunction

    function automatic logic [1:0] scale_shift(input logic [1:0] scode);
        return scode[1] ? 2'd2 : {1'b0, scode[0]};
    endfunction

    // Byte of page row 'row' after each bit of b is repeated scale times
    function automatic logic [7:0] spread_row(input logic [7:0] b,
                                              input logic [1:0] scode,
                                              input logic [1:0] row);
        logic [7:0] r;
        r = b;
        case (scode)
            2'd0: r = b;
            2'd1:
            begin
                for (int j = 0; j < 8; j++)
                begin
                    r[j] = b[{row[0], 2'(j / 2)}];
                end
            end
            default:
            begin
                for (int j = 0; j < 8; j++)
                begin
                    r[j] = b[{row, 1'(j / 4)}];
                end
            end
        endcase
        return r;
    endfunction

endpackage

[rtl/core/scaled_text_cell_renderer_core.sv]
// With the back end idle, an accepted print passes the queue entry, the walker's
// cell register and the result register before its first result is valid.
// A print yields 6 * scale results (6, 12 or 24), one result a cycle from the back end's
// column/page-row walker while res_stall is low; newline and set-position queue nothing.
// Up to two classified prints wait in the queue while the walker is busy.
// Reset clears the text position, the registers, the queue and the output.
// ----------------------------------------------------------------------------
// scaled_text_cell_renderer_core
// Text cell renderer for a page-organized display with 1x, 2x and 4x fonts.
// ----------------------------------------------------------------------------
module scaled_text_cell_renderer_core #(
    parameter int PANEL_WIDTH = 128
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cmd_valid,
    output logic                cmd_stall,
    input  stcr_pkg::stcr_cmd_t cmd,
    output logic                res_valid,
    input  logic                res_stall,
    output stcr_pkg::stcr_res_t res,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [4:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);
    import stcr_pkg::*;

    stcr_cfg_t  cfg_reg;
    stcr_cell_t front_cell, back_cell;
    logic       q_push, q_pop, q_full, q_valid;
    logic       cfg_write;
    logic [2:0] reg_index;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign reg_index = paddr[4:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_write)
        begin
            unique case (reg_index)
                REG_COLUMN_OFFSET: cfg_reg.column_offset <= pwdata[7:0];
                REG_SCALE_CODE:    cfg_reg.scale_code    <= pwdata[1:0];
                REG_CURSOR_ENABLE: cfg_reg.cursor_enable <= pwdata[0];
                REG_CURSOR_COL:    cfg_reg.cursor_col    <= pwdata[7:0];
                REG_CURSOR_ROW:    cfg_reg.cursor_row    <= pwdata[7:0];
                default:           cfg_reg               <= cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_index)
            REG_COLUMN_OFFSET: prdata = {24'd0, cfg_reg.column_offset};
            REG_SCALE_CODE:    prdata = {30'd0, cfg_reg.scale_code};
            REG_CURSOR_ENABLE: prdata = {31'd0, cfg_reg.cursor_enable};
            REG_CURSOR_COL:    prdata = {24'd0, cfg_reg.cursor_col};
            REG_CURSOR_ROW:    prdata = {24'd0, cfg_reg.cursor_row};
            default:           prdata = 32'd0;
        endcase
    end

    stcr_front #(
        .PANEL_WIDTH (PANEL_WIDTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .cfg       (cfg_reg),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_cell    (front_cell)
    );

    stcr_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (q_push),
        .wr_cell (front_cell),
        .full    (q_full),
        .pop     (q_pop),
        .valid   (q_valid),
        .rd_cell (back_cell)
    );

    stcr_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_cell    (back_cell),
        .q_pop     (q_pop),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res)
    );

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_full)
        else $error("cell pushed into full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_valid)
        else $error("cell popped from empty queue");

    a_print_only: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_valid && !cmd_stall && (cmd.func != FUNC_PRINT)) |-> !q_push)
        else $error("non-print transaction queued for rendering");

    a_repeat_legal: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (res.repeat_count == 3'd1 || res.repeat_count == 3'd2
                       || res.repeat_count == 3'd4))
        else $error("illegal repeat count");

endmodule

[rtl/core/stcr_front.sv]
// ----------------------------------------------------------------------------
// stcr_front
// Accepts items, keeps the text position, wraps and classifies prints.
// ----------------------------------------------------------------------------
module stcr_front #(
    parameter int PANEL_WIDTH = 128
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cmd_valid,
    output logic                cmd_stall,
    input  stcr_pkg::stcr_cmd_t cmd,
    input  stcr_pkg::stcr_cfg_t cfg,
    input  logic                q_full,
    output logic                q_push,
    output stcr_pkg::stcr_cell_t q_cell
);
    import stcr_pkg::*;

    localparam logic [7:0] LIMIT1 = 8'(PANEL_WIDTH / 6);
    localparam logic [7:0] LIMIT2 = 8'(PANEL_WIDTH / 12);
    localparam logic [7:0] LIMIT4 = 8'(PANEL_WIDTH / 24);

    logic [7:0] text_col_reg, text_col_next;
    logic [7:0] text_row_reg, text_row_next;
    logic       accept;
    logic [7:0] limit;
    logic       wrap;
    logic [7:0] col_w, row_w;
    logic [7:0] col6;
    logic [1:0] shamt;

    assign cmd_stall = q_full;
    assign accept    = cmd_valid && !cmd_stall;
    assign shamt     = scale_shift(cfg.scale_code);

    always_comb
    begin
        case (cfg.scale_code)
            2'd0:    limit = LIMIT1;
            2'd1:    limit = LIMIT2;
            default: limit = LIMIT4;
        endcase
    end

    assign wrap  = text_col_reg >= limit;
    assign col_w = wrap ? 8'd0 : text_col_reg;
    assign row_w = wrap ? text_row_reg + 8'd1 : text_row_reg;
    assign col6  = {col_w[5:0], 2'b00} + {col_w[6:0], 1'b0};

    always_comb
    begin
        q_cell.glyph[0]   = cmd.glyph_col_a;
        q_cell.glyph[1]   = cmd.glyph_col_b;
        q_cell.glyph[2]   = cmd.glyph_col_c;
        q_cell.glyph[3]   = cmd.glyph_col_d;
        q_cell.glyph[4]   = cmd.glyph_col_e;
        q_cell.cursor     = cfg.cursor_enable && (col_w == cfg.cursor_col)
                            && (row_w == cfg.cursor_row);
        q_cell.base_col   = cfg.column_offset + (col6 << shamt);
        q_cell.base_page  = row_w[3:0] << shamt;
        q_cell.scale_code = cfg.scale_code;
    end

    always_comb
    begin
        text_col_next = text_col_reg;
        text_row_next = text_row_reg;
        q_push        = 1'b0;
        if (accept)
        begin
            unique case (cmd.func)
                FUNC_PRINT:
                begin
                    q_push        = 1'b1;
                    text_col_next = col_w + 8'd1;
                    text_row_next = row_w;
                end
                FUNC_NEWLINE:
                begin
                    text_col_next = 8'd0;
                    text_row_next = text_row_reg + 8'd1;
                end
                FUNC_SETPOS:
                begin
                    text_col_next = cmd.new_col;
                    text_row_next = cmd.new_row;
                end
                default:
                begin
                    text_col_next = text_col_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            text_col_reg <= '0;
            text_row_reg <= '0;
        end
        else
        begin
            text_col_reg <= text_col_next;
            text_row_reg <= text_row_next;
        end
    end

endmodule

[rtl/core/stcr_queue.sv]
// ----------------------------------------------------------------------------
// stcr_queue
// Two-entry queue of classified cells between front and back.
// ----------------------------------------------------------------------------
module stcr_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  stcr_pkg::stcr_cell_t wr_cell,
    output logic                 full,
    input  logic                 pop,
    output logic                 valid,
    output stcr_pkg::stcr_cell_t rd_cell
);
    import stcr_pkg::*;

    stcr_cell_t entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    assign full    = count_reg == 2'd2;
    assign valid   = count_reg != 2'd0;
    assign rd_cell = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= wr_cell;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

[rtl/core/stcr_back.sv]
// ----------------------------------------------------------------------------
// stcr_back
// Walks a cell over its six columns and scaled page rows, one result a cycle unless res_stall holds it.
// ----------------------------------------------------------------------------
module stcr_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 q_valid,
    input  stcr_pkg::stcr_cell_t q_cell,
    output logic                 q_pop,
    output logic                 res_valid,
    input  logic                 res_stall,
    output stcr_pkg::stcr_res_t  res
);
    import stcr_pkg::*;

    stcr_back_state_t state_reg, state_next;
    stcr_cell_t       cell_reg;
    logic [2:0]       idx_reg, idx_next;
    logic [1:0]       row_reg, row_next;
    logic [7:0]       col_addr_reg, col_addr_next;
    logic             res_valid_reg, res_valid_next;
    stcr_res_t        res_reg;
    stcr_res_t        res_calc;
    logic             emit;
    logic             last_row, last;
    logic [2:0]       scale;
    logic [7:0]       col_byte;

    assign scale    = scale_of(cell_reg.scale_code);
    assign last_row = {1'b0, row_reg} == scale - 3'd1;
    assign last     = last_row && (idx_reg == 3'd5);
    assign emit     = (state_reg == BK_RUN) && (!res_valid_reg || !res_stall);
    assign q_pop    = q_valid && ((state_reg == BK_IDLE) || (emit && last));

    // Blank column first, then the five glyph columns
    always_comb
    begin
        case (idx_reg)
            3'd1:    col_byte = cell_reg.glyph[0];
            3'd2:    col_byte = cell_reg.glyph[1];
            3'd3:    col_byte = cell_reg.glyph[2];
            3'd4:    col_byte = cell_reg.glyph[3];
            3'd5:    col_byte = cell_reg.glyph[4];
            default: col_byte = 8'd0;
        endcase
        if (cell_reg.cursor)
        begin
            col_byte = col_byte | CURSOR_MARK;
        end
    end

    always_comb
    begin
        res_calc.column_addr  = col_addr_reg;
        res_calc.page_addr    = cell_reg.base_page + {2'b00, row_reg};
        res_calc.pixel_byte   = spread_row(col_byte, cell_reg.scale_code, row_reg);
        res_calc.repeat_count = scale;
        res_calc.last_of_cell = last;
    end

    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        row_next       = row_reg;
        col_addr_next  = col_addr_reg;
        res_valid_next = res_valid_reg && res_stall;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (q_valid)
                begin
                    state_next = BK_RUN;
                end
            end
            BK_RUN:
            begin
                if (emit)
                begin
                    res_valid_next = 1'b1;
                    if (last_row)
                    begin
                        row_next      = 2'd0;
                        idx_next      = idx_reg + 3'd1;
                        col_addr_next = col_addr_reg + {5'd0, scale};
                    end
                    else
                    begin
                        row_next = row_reg + 2'd1;
                    end
                    if (last && !q_valid)
                    begin
                        state_next = BK_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
        // Start the next cell from the head of the queue
        if (q_pop)
        begin
            idx_next      = 3'd0;
            row_next      = 2'd0;
            col_addr_next = q_cell.base_col;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            cell_reg <= q_cell;
        end
        if (emit)
        begin
            res_reg <= res_calc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            idx_reg       <= '0;
            row_reg       <= '0;
            col_addr_reg  <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            row_reg       <= row_next;
            col_addr_reg  <= col_addr_next;
            res_valid_reg <= res_valid_next;
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

[test/tb_scaled_text_cell_renderer_core.sv]
// ----------------------------------------------------------------------------
// tb_scaled_text_cell_renderer_core
// Self-checking bench for the text cell renderer. A behavioral copy of the
// renderer predicts every page byte of each accepted print. Results are
// compared field by field in order. Directed cells cover the extremes and the
// wrap cases. Random traffic runs under several register settings, with random
// gaps on the command side and random stalls on the result side.
// ----------------------------------------------------------------------------
module tb_scaled_text_cell_renderer_core;
    import stcr_pkg::*;

    class cell_render_model;
        int         panel_width;
        logic [7:0] column_offset;
        logic [1:0] scale_code;
        logic       cursor_enable;
        logic [7:0] cursor_col;
        logic [7:0] cursor_row;
        logic [7:0] text_col;
        logic [7:0] text_row;
        stcr_res_t  pending_bytes[$];
        int         errors;

        function new(int width);
            panel_width   = width;
            column_offset = 8'd0;
            scale_code    = 2'd0;
            cursor_enable = 1'b0;
            cursor_col    = 8'd0;
            cursor_row    = 8'd0;
            text_col      = 8'd0;
            text_row      = 8'd0;
            errors        = 0;
        endfunction

        function void set_reg(logic [2:0] idx, logic [31:0] value);
            case (idx)
                REG_COLUMN_OFFSET: column_offset = value[7:0];
                REG_SCALE_CODE:    scale_code    = value[1:0];
                REG_CURSOR_ENABLE: cursor_enable = value[0];
                REG_CURSOR_COL:    cursor_col    = value[7:0];
                REG_CURSOR_ROW:    cursor_row    = value[7:0];
                default: ;
            endcase
        endfunction

        // Update the text position and queue the page bytes a command produces
        function void accept_cmd(stcr_cmd_t c);
            int          scale;
            int          limit;
            int          caddr;
            int          page;
            logic [7:0]  cols [6];
            logic [7:0]  b;
            logic [31:0] wide;
            logic        on_cursor;
            stcr_res_t   e;
            case (c.func)
                FUNC_NEWLINE:
                begin
                    text_col = 8'd0;
                    text_row = text_row + 8'd1;
                end
                FUNC_SETPOS:
                begin
                    text_col = c.new_col;
                    text_row = c.new_row;
                end
                FUNC_PRINT:
                begin
                    scale = (scale_code == 2'd0) ? 1 : (scale_code == 2'd1) ? 2 : 4;
                    limit = panel_width / (scale * 6);
                    if (int'(text_col) >= limit)
                    begin
                        text_col = 8'd0;
                        text_row = text_row + 8'd1;
                    end
                    cols[0] = 8'h00;
                    cols[1] = c.glyph_col_a;
                    cols[2] = c.glyph_col_b;
                    cols[3] = c.glyph_col_c;
                    cols[4] = c.glyph_col_d;
                    cols[5] = c.glyph_col_e;
                    on_cursor = cursor_enable && (text_col == cursor_col) &&
                                (text_row == cursor_row);
                    for (int idx = 0; idx < 6; idx++)
                    begin
                        b = on_cursor ? (cols[idx] | CURSOR_MARK) : cols[idx];
                        // stretch each pixel bit over scale bits, top pixel first
                        wide = '0;
                        for (int i = 0; i < 8; i++)
                        begin
                            for (int k = 0; k < scale; k++)
                            begin
                                wide[i * scale + k] = b[i];
                            end
                        end
                        caddr = column_offset + idx * scale + text_col * scale * 6;
                        for (int r = 0; r < scale; r++)
                        begin
                            page           = r + text_row * scale;
                            e.column_addr  = caddr[7:0];
                            e.page_addr    = page[3:0];
                            e.pixel_byte   = wide[r * 8 +: 8];
                            e.repeat_count = scale[2:0];
                            e.last_of_cell = (idx == 5) && (r == scale - 1);
                            pending_bytes.push_back(e);
                        end
                    end
                    text_col = text_col + 8'd1;
                end
                default: ;
            endcase
        endfunction

        function void mismatch(string field, logic [7:0] want, logic [7:0] got);
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
            errors++;
        endfunction

        function void check_byte(stcr_res_t got);
            stcr_res_t want;
            if (pending_bytes.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual %h", $time, got);
                errors++;
                return;
            end
            want = pending_bytes.pop_front();
            if (got.column_addr !== want.column_addr)
                mismatch("column_addr", want.column_addr, got.column_addr);
            if (got.page_addr !== want.page_addr)
                mismatch("page_addr", 8'(want.page_addr), 8'(got.page_addr));
            if (got.pixel_byte !== want.pixel_byte)
                mismatch("pixel_byte", want.pixel_byte, got.pixel_byte);
            if (got.repeat_count !== want.repeat_count)
                mismatch("repeat_count", 8'(want.repeat_count), 8'(got.repeat_count));
            if (got.last_of_cell !== want.last_of_cell)
                mismatch("last_of_cell", 8'(want.last_of_cell), 8'(got.last_of_cell));
        endfunction
    endclass

    localparam int         PANEL_WIDTH     = 128;
    localparam int         NUM_PHASES      = 6;
    localparam int         ITEMS_PER_PHASE = 55;
    localparam logic [1:0] FUNC_UNUSED     = 2'd3;

    logic        clk;
    logic        rst_n;
    logic        cmd_valid;
    logic        cmd_stall;
    stcr_cmd_t   cmd;
    logic        res_valid;
    logic        res_stall;
    stcr_res_t   res;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    cell_render_model model;
    int               steady_left;

    scaled_text_cell_renderer_core #(
        .PANEL_WIDTH(PANEL_WIDTH)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd_valid(cmd_valid),
        .cmd_stall(cmd_stall),
        .cmd      (cmd),
        .res_valid(res_valid),
        .res_stall(res_stall),
        .res      (res),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && res_valid && !res_stall)
            model.check_byte(res);
    end

    // Result-side back pressure: short stalls mostly, a few long ones, and
    // now and then a long free-running stretch
    initial
    begin
        int hold;
        int run;
        res_stall = 1'b0;
        hold      = 0;
        run       = 0;
        forever
        begin
            @(negedge clk);
            if (hold > 0)
            begin
                res_stall <= 1'b1;
                hold--;
            end
            else
            begin
                res_stall <= 1'b0;
                if (run > 0)
                    run--;
                else
                begin
                    case ($urandom_range(0, 19))
                        0:       hold = $urandom_range(20, 40);
                        1, 2:    hold = $urandom_range(4, 10);
                        default: hold = $urandom_range(1, 3);
                    endcase
                    run = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 120)
                                                      : $urandom_range(0, 6);
                end
            end
        end
    end

    function automatic stcr_cmd_t rand_cmd(input logic [1:0] code);
        stcr_cmd_t c;
        c.func        = code;
        c.glyph_col_a = 8'($urandom_range(0, 255));
        c.glyph_col_b = 8'($urandom_range(0, 255));
        c.glyph_col_c = 8'($urandom_range(0, 255));
        c.glyph_col_d = 8'($urandom_range(0, 255));
        c.glyph_col_e = 8'($urandom_range(0, 255));
        c.new_col     = 8'($urandom_range(0, 255));
        c.new_row     = 8'($urandom_range(0, 255));
        return c;
    endfunction

    // Present one command after a random gap and hold it until it is taken
    task automatic send_cmd(input stcr_cmd_t c);
        int gap;
        if (steady_left > 0)
        begin
            gap = 0;
            steady_left--;
        end
        else
        begin
            case ($urandom_range(0, 19))
                0:             gap = $urandom_range(15, 40);
                1, 2, 3:       gap = $urandom_range(4, 8);
                4, 5, 6, 7, 8: gap = $urandom_range(1, 3);
                default:       gap = 0;
            endcase
            if ($urandom_range(0, 7) == 0)
                steady_left = $urandom_range(10, 40);
        end
        if (gap > 0)
        begin
            cmd_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        cmd       <= c;
        cmd_valid <= 1'b1;
        @(posedge clk);
        while (cmd_stall)
            @(posedge clk);
        model.accept_cmd(c);
        @(negedge clk);
    endtask

    task automatic print_glyph(input logic [7:0] a, input logic [7:0] b,
                               input logic [7:0] c, input logic [7:0] d,
                               input logic [7:0] e);
        stcr_cmd_t item;
        item             = rand_cmd(FUNC_PRINT);
        item.glyph_col_a = a;
        item.glyph_col_b = b;
        item.glyph_col_c = c;
        item.glyph_col_d = d;
        item.glyph_col_e = e;
        send_cmd(item);
    endtask

    task automatic move_to(input logic [7:0] col, input logic [7:0] row);
        stcr_cmd_t item;
        item         = rand_cmd(FUNC_SETPOS);
        item.new_col = col;
        item.new_row = row;
        send_cmd(item);
    endtask

    // Drop valid, wait out every expected byte, then let non-print commands
    // still in flight settle
    task automatic drain_block(input int settle);
        cmd_valid <= 1'b0;
        while (model.pending_bytes.size() != 0)
            @(negedge clk);
        repeat (settle) @(negedge clk);
    endtask

    // Write one register, then read it back
    task automatic cfg_write(input logic [2:0] idx, input logic [31:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        model.set_reg(idx, value);
        @(negedge clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (prdata !== value)
        begin
            $display("%0t: register %0d readback mismatch, expected %0h, actual %0h",
                     $time, idx, value, prdata);
            model.errors++;
        end
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic configure(input stcr_cfg_t cfg);
        drain_block(8);
        cfg_write(REG_COLUMN_OFFSET, {24'd0, cfg.column_offset});
        cfg_write(REG_SCALE_CODE, {30'd0, cfg.scale_code});
        cfg_write(REG_CURSOR_ENABLE, {31'd0, cfg.cursor_enable});
        cfg_write(REG_CURSOR_COL, {24'd0, cfg.cursor_col});
        cfg_write(REG_CURSOR_ROW, {24'd0, cfg.cursor_row});
    endtask

    initial
    begin
        stcr_cmd_t item;
        stcr_cfg_t cfg;
        int        scale;
        int        limit;
        int        roll;
        cmd_valid   = 1'b0;
        cmd         = '0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        rst_n       = 1'b0;
        steady_left = 0;
        model       = new(PANEL_WIDTH);
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Reset settings: scale 1, no offset, cursor off
        print_glyph(8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
        print_glyph(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
        print_glyph(8'h01, 8'h80, 8'h55, 8'hAA, 8'h3C);
        send_cmd(rand_cmd(FUNC_NEWLINE));
        send_cmd(rand_cmd(FUNC_UNUSED));
        // wrap from the far corner: both column and row roll over
        move_to(8'd255, 8'd255);
        print_glyph(8'h81, 8'h42, 8'h24, 8'h18, 8'hFF);
        // last cell on the line, then an automatic wrap
        move_to(8'd20, 8'd3);
        print_glyph(8'h0F, 8'hF0, 8'h33, 8'hCC, 8'h99);
        print_glyph(8'h7E, 8'h81, 8'h81, 8'h81, 8'h7E);
        move_to(8'd0, 8'd255);
        send_cmd(rand_cmd(FUNC_NEWLINE));

        // Scale 4 with maximum offset: column addresses overflow
        cfg = '{column_offset: 8'd255, scale_code: 2'd3, cursor_enable: 1'b1,
                cursor_col: 8'd2, cursor_row: 8'd5};
        configure(cfg);
        move_to(8'd2, 8'd5);
        print_glyph(8'hFF, 8'h00, 8'hFF, 8'h00, 8'h01);
        // page rows 12..15 on two neighboring cells
        move_to(8'd1, 8'd3);
        print_glyph(8'h80, 8'h40, 8'h20, 8'h10, 8'h08);
        print_glyph(8'h01, 8'h02, 8'h04, 8'h08, 8'h10);
        // page addresses past 15 keep their low bits
        move_to(8'd4, 8'd4);
        print_glyph(8'hA5, 8'h5A, 8'hC3, 8'h3C, 8'hE7);
        print_glyph(8'h11, 8'h22, 8'h44, 8'h88, 8'hFF);

        // Scale 2, cursor disabled over a matching position
        cfg = '{column_offset: 8'd200, scale_code: 2'd1, cursor_enable: 1'b0,
                cursor_col: 8'd2, cursor_row: 8'd5};
        configure(cfg);
        move_to(8'd2, 8'd5);
        print_glyph(8'hFF, 8'h7F, 8'h3F, 8'h1F, 8'h0F);

        // Scale 4 through code 2; a wrap lands on the cursor cell
        cfg = '{column_offset: 8'd17, scale_code: 2'd2, cursor_enable: 1'b1,
                cursor_col: 8'd0, cursor_row: 8'd6};
        configure(cfg);
        move_to(8'd5, 8'd5);
        print_glyph(8'h00, 8'h55, 8'hAA, 8'hFF, 8'h00);
        print_glyph(8'hC0, 8'h30, 8'h0C, 8'h03, 8'h81);

        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            cfg.column_offset = 8'($urandom_range(0, 255));
            cfg.cursor_enable = 1'b1;
            case (ph)
                0:
                begin
                    cfg.scale_code = 2'd0;
                    cfg.cursor_col = 8'($urandom_range(0, 20));
                    cfg.cursor_row = 8'($urandom_range(0, 7));
                end
                1:
                begin
                    cfg.scale_code = 2'd1;
                    cfg.cursor_col = 8'($urandom_range(0, 9));
                    cfg.cursor_row = 8'($urandom_range(0, 7));
                end
                2:
                begin
                    cfg = '{column_offset: 8'd255, scale_code: 2'd2, cursor_enable: 1'b0,
                            cursor_col: 8'd255, cursor_row: 8'd255};
                end
                3:
                begin
                    cfg.scale_code = 2'd3;
                    cfg.cursor_col = 8'($urandom_range(0, 4));
                    cfg.cursor_row = 8'($urandom_range(0, 15));
                end
                4:
                begin
                    cfg.scale_code    = 2'($urandom_range(0, 3));
                    cfg.cursor_enable = 1'($urandom_range(0, 1));
                    cfg.cursor_col    = 8'($urandom_range(0, 255));
                    cfg.cursor_row    = 8'($urandom_range(0, 255));
                end
                default:
                begin
                    cfg = '0;
                end
            endcase
            configure(cfg);
            scale = (cfg.scale_code == 2'd0) ? 1 : (cfg.scale_code == 2'd1) ? 2 : 4;
            limit = PANEL_WIDTH / (scale * 6);
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                roll = $urandom_range(0, 99);
                item = rand_cmd(FUNC_PRINT);
                if (roll >= 60 && roll < 68)
                    item.func = FUNC_NEWLINE;
                else if (roll >= 68 && roll < 82)
                begin
                    item.func    = FUNC_SETPOS;
                    item.new_col = 8'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 255)
                                                                  : $urandom_range(0, limit + 1));
                    item.new_row = 8'(($urandom_range(0, 1) == 0) ? $urandom_range(0, 255)
                                                                  : $urandom_range(0, 7));
                end
                else if (roll >= 82 && roll < 91)
                begin
                    // jump onto the cursor cell so the next print marks it
                    item.func    = FUNC_SETPOS;
                    item.new_col = cfg.cursor_col;
                    item.new_row = cfg.cursor_row;
                end
                else if (roll >= 91)
                    item.func = FUNC_UNUSED;
                send_cmd(item);
            end
        end

        drain_block(20);
        if (model.errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        #20000000;
        $display("Test completed with failures");
        $finish;
    end

endmodule
